// File: design/atrp_pkg.sv
`default_nettype none
package atrp_pkg;

	localparam int GUARD_BITS = 8;
	localparam int ACC_FRAC   = 24;
	localparam int TABLE_LEN  = 24;
	localparam int ACC_W      = 34;

	localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sd3019898880;

	typedef logic signed [ACC_W-1:0] acc_t;

	function automatic acc_t atan_entry(input int i);
		acc_t v;
		unique case (i)
			0: v = 34'sd754974720;
			1: v = 34'sd445687602;
			2: v = 34'sd235489088;
			3: v = 34'sd119537938;
			4: v = 34'sd60000934;
			5: v = 34'sd30029717;
			6: v = 34'sd15018523;
			7: v = 34'sd7509720;
			8: v = 34'sd3754917;
			9: v = 34'sd1877466;
			10: v = 34'sd938734;
			11: v = 34'sd469367;
			12: v = 34'sd234684;
			13: v = 34'sd117342;
			14: v = 34'sd58671;
			15: v = 34'sd29335;
			16: v = 34'sd14668;
			17: v = 34'sd7334;
			18: v = 34'sd3667;
			19: v = 34'sd1833;
			20: v = 34'sd917;
			21: v = 34'sd458;
			22: v = 34'sd229;
			23: v = 34'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: design/atrp_if.sv
`default_nettype none
interface atrp_if #(
	parameter int PAYLOAD_W = 48
) (
	input wire logic clk
);
	logic                 valid;
	logic                 ready;
	logic [PAYLOAD_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/atrp_sqrt_cell.sv
`default_nettype none
// One restoring step of a digit-by-digit square root, two radicand bits per cell.
module atrp_sqrt_cell import atrp_pkg::*; #(
	parameter int RAD_W = 48,
	parameter int ROOT_W = 24
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad_in,
	input  wire logic [ROOT_W+1:0] rem_in,
	input  wire logic [ROOT_W-1:0] root_in,
	output logic      [RAD_W-1:0]  rad_out,
	output logic      [ROOT_W+1:0] rem_out,
	output logic      [ROOT_W-1:0] root_out
);
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	always_comb begin
		rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
		trial  = {root_in, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_out  <= fits ? (rem_sh - trial) : rem_sh;
			root_out <= {root_in[ROOT_W-2:0], fits};
		end
	end
endmodule
`default_nettype wire

// File: design/atrp_cordic_cell.sv
`default_nettype none
// One vectoring CORDIC micro-rotation.
module atrp_cordic_cell import atrp_pkg::*; #(
	parameter int DW = 36,
	parameter int STAGE = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic signed [DW-1:0] a_in,
	input  wire logic signed [DW-1:0] b_in,
	input  wire acc_t          acc_in,
	output logic signed [DW-1:0] a_out,
	output logic signed [DW-1:0] b_out,
	output acc_t               acc_out
);
	logic signed [DW-1:0] as, bs;
	acc_t                 step;

	always_comb begin
		as   = a_in >>> STAGE;
		bs   = b_in >>> STAGE;
		step = atan_entry(STAGE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!a_in[DW-1]) begin
				b_out   <= b_in + as;
				a_out   <= a_in - bs;
				acc_out <= acc_in + step;
			end else begin
				b_out   <= b_in - as;
				a_out   <= a_in + bs;
				acc_out <= acc_in - step;
			end
		end
	end
endmodule
`default_nettype wire

// File: design/accel_tilt_roll_pitch_unit.sv
`default_nettype none
// Accelerometer tilt unit: roll = atan2(x, sqrt(y*y+z*z)), pitch = atan2(y, z).
// Input channel sample_in carries {accel_z, accel_y, accel_x}; output channel
// angle_out carries {pitch_angle, roll_angle}, both in 1/2^ANGLE_FRAC_BITS degree.
// A transaction is taken on every clock edge where valid and ready are high.
// Throughput is one sample per cycle unless the receiver stalls. A sample
// passes through the row of square-root cells, a set-up register, the row of
// rotation cells and the output register, into which the angles are rounded.
// The whole pipeline advances as one; when the receiver stalls with a result
// waiting, every stage holds and ready drops, so nothing is lost.
// Reset clears only the valid bits of the pipeline and output register.
module accel_tilt_roll_pitch_unit import atrp_pkg::*; #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int CORDIC_STAGES   = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	atrp_if.sink     sample_in,
	atrp_if.source   angle_out
);
	localparam int SW     = SAMPLE_WIDTH;
	localparam int ROOT_W = SW + GUARD_BITS;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int DW     = SW + GUARD_BITS + 4;
	localparam int NST    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int SQ_N   = ROOT_W;
	localparam int DEPTH  = SQ_N + 1 + NST;
	localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam acc_t ROLL_LIM  = acc_t'(90 * (1 << ANGLE_FRAC_BITS));
	localparam acc_t PITCH_LIM = acc_t'(180 * (1 << ANGLE_FRAC_BITS));
	localparam acc_t RND       = acc_t'(1) <<< (SH - 1);

	logic              adv;
	logic [DEPTH-1:0]  vld_q;
	logic              out_vld_q;
	logic [14:0]       roll_q;
	logic [15:0]       pitch_q;

	assign adv             = !out_vld_q || angle_out.ready;
	assign sample_in.ready = adv;

	logic signed [SW-1:0] x_in, y_in, z_in;
	assign x_in = sample_in.data[SW-1:0];
	assign y_in = sample_in.data[2*SW-1:SW];
	assign z_in = sample_in.data[3*SW-1:2*SW];

	// Squares taken on entry; x, y and z travel alongside the root cells.
	logic [SW-1:0]      ay, az;
	logic [RAD_W-1:0]   rad0;
	assign ay   = y_in[SW-1] ? SW'(-y_in) : SW'(y_in);
	assign az   = z_in[SW-1] ? SW'(-z_in) : SW'(z_in);
	assign rad0 = ({{(RAD_W-SW){1'b0}}, ay} * ay + {{(RAD_W-SW){1'b0}}, az} * az)
		<< (2 * GUARD_BITS);

	logic [RAD_W-1:0]    rad_c  [SQ_N+1];
	logic [ROOT_W+1:0]   rem_c  [SQ_N+1];
	logic [ROOT_W-1:0]   root_c [SQ_N+1];
	logic [3*SW-1:0]     xyz_c  [SQ_N+1];
	assign rad_c[0]  = rad0;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign xyz_c[0]  = sample_in.data[3*SW-1:0];

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		atrp_sqrt_cell #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_cell (
			.clk(clk), .en(adv),
			.rad_in(rad_c[k]), .rem_in(rem_c[k]), .root_in(root_c[k]),
			.rad_out(rad_c[k+1]), .rem_out(rem_c[k+1]), .root_out(root_c[k+1])
		);
		always_ff @(posedge clk) begin
			if (adv) xyz_c[k+1] <= xyz_c[k];
		end
	end

	// Pre-rotation: zero cases and the half turn for a negative denominator.
	logic signed [DW-1:0] ra, rb, pa, pb;
	logic signed [DW-1:0] ra_s1, rb_s1, pa_s1, pb_s1;
	acc_t                 roff_s1, poff_s1;
	logic                 rzero_s1, pzero_s1;
	logic signed [SW-1:0] xs, ys, zs;
	assign xs = xyz_c[SQ_N][SW-1:0];
	assign ys = xyz_c[SQ_N][2*SW-1:SW];
	assign zs = xyz_c[SQ_N][3*SW-1:2*SW];
	assign ra = DW'(xs) <<< GUARD_BITS;
	assign rb = DW'({1'b0, root_c[SQ_N]});
	assign pa = DW'(ys) <<< GUARD_BITS;
	assign pb = DW'(zs) <<< GUARD_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			rzero_s1 <= (ra == '0) && (rb == '0);
			pzero_s1 <= (pa == '0) && (pb == '0);
			ra_s1    <= ra;
			rb_s1    <= rb;
			roff_s1  <= '0;
			if (pb[DW-1]) begin
				pa_s1   <= -pa;
				pb_s1   <= -pb;
				poff_s1 <= pa[DW-1] ? -HALF_TURN : HALF_TURN;
			end else begin
				pa_s1   <= pa;
				pb_s1   <= pb;
				poff_s1 <= '0;
			end
		end
	end

	logic signed [DW-1:0] rac [NST+1], rbc [NST+1], pac [NST+1], pbc [NST+1];
	acc_t                 racc [NST+1], pacc [NST+1], roffc [NST+1], poffc [NST+1];
	logic                 rzc [NST+1], pzc [NST+1];
	assign rac[0] = ra_s1;  assign rbc[0] = rb_s1;  assign racc[0] = '0;
	assign pac[0] = pa_s1;  assign pbc[0] = pb_s1;  assign pacc[0] = '0;
	assign roffc[0] = roff_s1; assign poffc[0] = poff_s1;
	assign rzc[0] = rzero_s1;  assign pzc[0] = pzero_s1;

	for (genvar i = 0; i < NST; i++) begin : g_cord
		atrp_cordic_cell #(.DW(DW), .STAGE(i)) u_roll (
			.clk(clk), .en(adv), .a_in(rac[i]), .b_in(rbc[i]), .acc_in(racc[i]),
			.a_out(rac[i+1]), .b_out(rbc[i+1]), .acc_out(racc[i+1])
		);
		atrp_cordic_cell #(.DW(DW), .STAGE(i)) u_pitch (
			.clk(clk), .en(adv), .a_in(pac[i]), .b_in(pbc[i]), .acc_in(pacc[i]),
			.a_out(pac[i+1]), .b_out(pbc[i+1]), .acc_out(pacc[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				roffc[i+1] <= roffc[i];
				poffc[i+1] <= poffc[i];
				rzc[i+1]   <= rzc[i];
				pzc[i+1]   <= pzc[i];
			end
		end
	end

	// Rounding and clamping.
	acc_t rsum, psum, rr, pr, rcl, pcl;
	always_comb begin
		rsum = rzc[NST] ? '0 : racc[NST] + roffc[NST];
		psum = pzc[NST] ? '0 : pacc[NST] + poffc[NST];
		rr   = (rsum + RND) >>> SH;
		pr   = (psum + RND) >>> SH;
		rcl  = (rr > ROLL_LIM) ? ROLL_LIM : ((rr < -ROLL_LIM) ? -ROLL_LIM : rr);
		pcl  = (pr > PITCH_LIM) ? PITCH_LIM : ((pr < -PITCH_LIM) ? -PITCH_LIM : pr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= rcl[14:0];
			pitch_q <= pcl[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[DEPTH-2:0], sample_in.valid};
			out_vld_q <= vld_q[DEPTH-1];
		end
	end

	assign angle_out.valid = out_vld_q;
	assign angle_out.data  = {pitch_q, roll_q};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_out.valid && !angle_out.ready |=> $stable(vld_q))
		else $error("pipeline moved during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!angle_out.valid |-> sample_in.ready)
		else $error("ready low with empty output");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_out.valid |-> ($signed(roll_q) <= 15'sd11520 && $signed(roll_q) >= -15'sd11520))
		else $error("roll out of range");
endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atrp_pkg::*;

	localparam int LATENCY = 42;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_SAMPLES = 1700;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic signed [14:0] roll;
	} tilt_t;

	// Shift with rounding toward minus infinity, as the pipeline does.
	function automatic longint floor_shift(longint v, int n);
		if (v >= 0)
			return v >>> n;
		return -1 - ((-1 - v) >>> n);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// Vectoring rotation; result in units of 2^-24 degree.
	function automatic longint vector_angle(longint a, longint b);
		longint off, acc, bs, as_;
		off = 0;
		acc = 0;
		if (a == 0 && b == 0)
			return 0;
		if (b < 0) begin
			off = (a >= 0) ? 64'sd3019898880 : -64'sd3019898880;
			a = -a;
			b = -b;
		end
		for (int i = 0; i < 16; i++) begin
			bs = floor_shift(b, i);
			as_ = floor_shift(a, i);
			if (a >= 0) begin
				b = b + as_;
				a = a - bs;
				acc += longint'(atan_entry(i));
			end else begin
				b = b - as_;
				a = a + bs;
				acc -= longint'(atan_entry(i));
			end
		end
		return acc + off;
	endfunction

	function automatic longint round_clamp(longint acc, longint deg);
		longint lim, r;
		lim = deg * 128;
		r = floor_shift(acc + (64'sd1 << 16), 17);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic tilt_t tilt_of(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		tilt_t t;
		longint sum, den;
		sum = longint'(y) * y + longint'(z) * z;
		den = int_sqrt(longint'(sum) << 16);
		t.roll = 15'(round_clamp(vector_angle(longint'(x) * 256, den), 90));
		t.pitch = 16'(round_clamp(vector_angle(longint'(y) * 256, longint'(z) * 256), 180));
		return t;
	endfunction

	class tilt_scoreboard;
		tilt_t pending[$];
		int errors = 0;

		function void note_sample(logic [47:0] d);
			pending.push_back(tilt_of(d[15:0], d[31:16], d[47:32]));
		endfunction

		function void check_angles(logic [30:0] d);
			tilt_t want, got;
			got = d;
			if (pending.size() == 0) begin
				$error("unexpected result roll=%0d pitch=%0d", got.roll, got.pitch);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.roll !== want.roll) begin
				$error("roll_angle: expected %0d, got %0d", want.roll, got.roll);
				errors++;
			end
			if (got.pitch !== want.pitch) begin
				$error("pitch_angle: expected %0d, got %0d", want.pitch, got.pitch);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int gap_pct = 36;
	int stall_pct = 36;
	int idle_count = 0;
	tilt_scoreboard sb;

	atrp_if #(.PAYLOAD_W(48)) sample_in (.clk(clk));
	atrp_if #(.PAYLOAD_W(31)) angle_out (.clk(clk));

	accel_tilt_roll_pitch_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(sample_in),
		.angle_out(angle_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		sample_in.valid = 0;
		sample_in.data = '0;
		angle_out.ready = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_in.valid && sample_in.ready)
				sb.note_sample(sample_in.data);
			if (angle_out.valid && angle_out.ready)
				sb.check_angles(angle_out.data);
			angle_out.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((sample_in.valid && sample_in.ready) || (angle_out.valid && angle_out.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < gap_pct) begin
			sample_in.valid <= 0;
			@(posedge clk);
		end
		sample_in.valid <= 1;
		sample_in.data <= {z, y, x};
		@(posedge clk);
		while (!sample_in.ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		sample_in.valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(8)) - 4);
			3: return 16'($urandom_range(16383) + 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] ext[5];
		sb = new();
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
		@(posedge arst_n);
		@(posedge clk);
		// Extremes, both-zero pitch, zero numerator over a negative denominator.
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h7fff, 16'h0000, 16'h0000);
		send_sample(16'h8000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h8000);
		send_sample(16'h0000, 16'hffff, 16'h8000);
		for (int i = 0; i < 5; i++)
			send_sample(ext[i], ext[(i + 2) % 5], ext[(i + 3) % 5]);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff);
		drain_results();
		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n == 400) begin
				gap_pct = 0;
				stall_pct = 0;
			end
			if (n == 700) begin
				gap_pct = 36;
				stall_pct = 36;
				drain_results();
			end
			send_sample(rand_axis(), rand_axis(), rand_axis());
		end
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
